// ===== src/rfn_pkg.sv =====
// Shared widths, sequencing constants and interface structs for the residual frame normalizer.
// No dependencies; every other file in src imports this package.
package rfn_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int RES_W          = 17;
    localparam int ACC_W          = 38;
    localparam int MAG_W          = 32;
    localparam int RATIO_W        = 16;
    localparam int CFG_W          = 7;
    localparam int MAX_WINDOW_DEF = 64;

    // Ratio is Q8.8, means are Q1.31.
    localparam int RATIO_FRAC = 8;
    localparam int MEAN_FRAC  = MAG_W - 1;

    // Threshold 0.01 is tested as 100 * R > n * 2^31.
    localparam int THR_MUL = 100;
    localparam int THR_W   = ACC_W + 7;

    // Divider numerator holds |residual| * magnitude, the widest dividend.
    localparam int NUM_W  = RES_W + MAG_W;
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam logic [STEP_W-1:0] MEAN_STEPS  = STEP_W'(ACC_W);
    localparam logic [STEP_W-1:0] RATIO_STEPS = STEP_W'(ACC_W + RATIO_FRAC);
    localparam logic [STEP_W-1:0] SCALE_STEPS = STEP_W'(RES_W);

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  preload;
        logic [NUM_W-1:0]  numer;
        logic [ACC_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic load;
        logic mul;
        logic add;
        logic clear;
    } t_acc_ctrl;

endpackage

// ===== src/residual_frame_normalizer.sv =====
// Top level of the residual frame normalizer: sequencer, residual store and output register.
// Depends on rfn_pkg, rfn_accum and rfn_divider.
//
//  channel   handshake                  payload
//  --------  -------------------------  ---------------------------------------------------
//  input     i_in_valid / o_in_stall    i_orig_sample, i_synth_sample, i_window_coef
//  output    o_out_valid / i_out_stall  o_residual_sample, o_energy_ratio,
//                                       o_above_threshold, o_frame_last
//  config    i_cfg_we                   i_cfg_wdata (window_size)
//
// Each input request passes through the accept, a multiply state and an accumulate state.
// When a frame closes, the threshold is tested; above the threshold two mean divisions and
// the ratio division follow, one after another on the one shared bit-serial divider.
// Draining then handles one sample at a time, unscaled or, when scaled, with a multiply plus
// a 17-step division, and waits while the output side stalls.
// Reset is synchronous and active low;
// the residual store is never cleared, since only entries of the current frame are read.
module residual_frame_normalizer #(
    parameter int MAX_WINDOW = rfn_pkg::MAX_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration
    input  logic                                i_cfg_we,
    input  logic [rfn_pkg::CFG_W-1:0]           i_cfg_wdata,
    // Input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [rfn_pkg::SAMPLE_W-1:0] i_orig_sample,
    input  logic signed [rfn_pkg::SAMPLE_W-1:0] i_synth_sample,
    input  logic [rfn_pkg::COEF_W-1:0]          i_window_coef,
    // Output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rfn_pkg::RES_W-1:0]    o_residual_sample,
    output logic [rfn_pkg::RATIO_W-1:0]         o_energy_ratio,
    output logic                                o_above_threshold,
    output logic                                o_frame_last
);
    import rfn_pkg::*;

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam logic [CFG_W-1:0] WIN_MIN = CFG_W'(2);
    localparam logic [CFG_W-1:0] WIN_MAX = CFG_W'(MAX_WINDOW);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_MUL     = 16'h0002,
        S_ADD     = 16'h0004,
        S_THR     = 16'h0008,
        S_RM_GO   = 16'h0010,
        S_RM_WAIT = 16'h0020,
        S_OM_GO   = 16'h0040,
        S_OM_WAIT = 16'h0080,
        S_RT_GO   = 16'h0100,
        S_RT_WAIT = 16'h0200,
        S_RD      = 16'h0400,
        S_ABS     = 16'h0800,
        S_SMUL    = 16'h1000,
        S_SD_GO   = 16'h2000,
        S_SD_WAIT = 16'h4000,
        S_OUT     = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Control state
    logic [CFG_W-1:0] r_window;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_rd_idx;
    logic [MAG_W-1:0] r_sres;
    logic [MAG_W-1:0] r_sorig;
    logic             r_out_valid;

    // Frame and drain datapath
    logic [ACC_W-1:0]        r_rmean;
    logic                    r_above;
    logic                    r_scale;
    logic [RATIO_W-1:0]      r_ratio;
    logic signed [RES_W-1:0] r_rdata;
    logic                    r_sign;
    logic [RES_W-1:0]        r_mag;
    logic [NUM_W-1:0]        r_prod;
    logic signed [RES_W-1:0] r_result;

    // Output register
    logic signed [RES_W-1:0] r_out_res;
    logic [RATIO_W-1:0]      r_out_ratio;
    logic                    r_out_above;
    logic                    r_out_last;

    // The residual store; a frame never holds more than MAX_WINDOW samples.
    logic signed [RES_W-1:0] r_mem [MAX_WINDOW];

    logic                    accept;
    logic signed [RES_W-1:0] in_res;
    logic [RES_W-1:0]        in_res_mag;
    logic [SAMPLE_W-1:0]     in_orig_mag;
    logic [CFG_W-1:0]        frame_len;
    logic                    frame_close;
    logic [THR_W-1:0]        thr_lhs;
    logic [THR_W-1:0]        thr_rhs;
    logic                    above;
    logic                    last;
    logic                    can_load;
    logic [ACC_W:0]          sres_sum;
    logic [ACC_W:0]          sorig_sum;
    logic [ACC_W-1:0]        res_acc;
    logic [ACC_W-1:0]        orig_acc;
    t_acc_ctrl               acc_ctrl;
    t_div_req                div_req;
    t_div_rsp                div_rsp;

    // Requests are taken only between frames' sample work; the skid is the output register.
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Residual and magnitudes of the incoming request.
    assign in_res      = RES_W'(i_orig_sample) - RES_W'(i_synth_sample);
    assign in_res_mag  = in_res[RES_W-1] ? (~in_res + 1'b1) : in_res;
    assign in_orig_mag = i_orig_sample[SAMPLE_W-1] ? (~i_orig_sample + 1'b1) : i_orig_sample;

    // The frame length register is clamped into the supported range before use.
    always_comb begin
        if (r_window < WIN_MIN) begin
            frame_len = WIN_MIN;
        end else if (r_window > WIN_MAX) begin
            frame_len = WIN_MAX;
        end else begin
            frame_len = r_window;
        end
    end

    // A lowered frame length closes the frame as soon as the held count reaches it.
    assign frame_close = (CFG_W'(r_count) >= frame_len);

    // Exact threshold test: 100 * R against n in Q1.31.
    assign thr_lhs = THR_W'(res_acc) * THR_W'(THR_MUL);
    assign thr_rhs = THR_W'(r_count) << MEAN_FRAC;
    assign above   = (thr_lhs > thr_rhs);

    assign last     = ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_count);
    assign can_load = !r_out_valid || !i_out_stall;

    // Smoothing averages the new frame mean with the running value, then drops to 32 bits.
    assign sres_sum  = {1'b0, r_rmean} + (ACC_W + 1)'(r_sres);
    assign sorig_sum = {1'b0, div_rsp.quot[ACC_W-1:0]} + (ACC_W + 1)'(r_sorig);

    assign acc_ctrl.load  = accept;
    assign acc_ctrl.mul   = (r_state == S_MUL);
    assign acc_ctrl.add   = (r_state == S_ADD);
    assign acc_ctrl.clear = (r_state == S_OUT) && can_load && last;

    rfn_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (acc_ctrl),
        .i_res_mag  (in_res_mag),
        .i_orig_mag (in_orig_mag),
        .i_coef     (i_window_coef),
        .o_res_acc  (res_acc),
        .o_orig_acc (orig_acc)
    );

    // Divider operands. Dividends are left-aligned so the first step sees their top bit.
    // For scaling the quotient fits in the residual width, so the top part of the
    // product goes straight into the partial remainder.
    always_comb begin
        div_req = '0;
        unique case (r_state)
            S_RM_GO: begin
                div_req.start   = 1'b1;
                div_req.numer   = NUM_W'(res_acc) << (NUM_W - ACC_W);
                div_req.divisor = ACC_W'(r_count);
                div_req.steps   = MEAN_STEPS;
            end
            S_OM_GO: begin
                div_req.start   = 1'b1;
                div_req.numer   = NUM_W'(orig_acc) << (NUM_W - ACC_W);
                div_req.divisor = ACC_W'(r_count);
                div_req.steps   = MEAN_STEPS;
            end
            S_RT_GO: begin
                div_req.start   = (orig_acc != '0);
                div_req.numer   = NUM_W'(res_acc) << (NUM_W - ACC_W);
                div_req.divisor = orig_acc;
                div_req.steps   = RATIO_STEPS;
            end
            S_SD_GO: begin
                div_req.start   = 1'b1;
                div_req.preload = ACC_W'(r_prod[NUM_W-1:RES_W]);
                div_req.numer   = NUM_W'(r_prod[RES_W-1:0]) << MAG_W;
                div_req.divisor = ACC_W'(r_sres);
                div_req.steps   = SCALE_STEPS;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    rfn_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer: sample intake, frame close, then one pass over the store per frame.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = frame_close ? S_THR : S_IDLE;
            end
            S_THR: begin
                n_state = above ? S_RM_GO : S_RD;
            end
            S_RM_GO: begin
                n_state = S_RM_WAIT;
            end
            S_RM_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_OM_GO;
                end
            end
            S_OM_GO: begin
                n_state = S_OM_WAIT;
            end
            S_OM_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_RT_GO;
                end
            end
            S_RT_GO: begin
                // A zero original sum skips the division and saturates the ratio.
                n_state = (orig_acc == '0) ? S_RD : S_RT_WAIT;
            end
            S_RT_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_ABS;
            end
            S_ABS: begin
                n_state = r_scale ? S_SMUL : S_OUT;
            end
            S_SMUL: begin
                n_state = S_SD_GO;
            end
            S_SD_GO: begin
                n_state = S_SD_WAIT;
            end
            S_SD_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (can_load) begin
                    n_state = last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= CFG_W'(MAX_WINDOW_DEF);
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_sres      <= '0;
            r_sorig     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (accept) begin
                r_count <= r_count + CNT_W'(1);
            end else if (acc_ctrl.clear) begin
                r_count <= '0;
            end
            if (r_state == S_THR) begin
                r_rd_idx <= '0;
            end else if ((r_state == S_OUT) && can_load && !last) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
            end
            if ((r_state == S_OM_WAIT) && div_rsp.done) begin
                r_sres  <= sres_sum[MAG_W:1];
                r_sorig <= sorig_sum[MAG_W:1];
            end
            if ((r_state == S_OUT) && can_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Residual store: written on accept, read with a registered port during the drain.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_count[IDX_W-1:0]] <= in_res;
        end
        r_rdata <= r_mem[r_rd_idx];
    end

    // Frame and drain datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_THR: begin
                r_above <= above;
                if (!above) begin
                    r_ratio <= '0;
                    r_scale <= 1'b0;
                end
            end
            S_RM_WAIT: begin
                if (div_rsp.done) begin
                    r_rmean <= div_rsp.quot[ACC_W-1:0];
                end
            end
            S_RT_GO: begin
                // The smoothed magnitudes were updated on the previous edge.
                r_scale <= (r_sres > r_sorig);
                if (orig_acc == '0) begin
                    r_ratio <= '1;
                end
            end
            S_RT_WAIT: begin
                if (div_rsp.done) begin
                    if (|div_rsp.quot[NUM_W-1:RATIO_W]) begin
                        r_ratio <= '1;
                    end else begin
                        r_ratio <= div_rsp.quot[RATIO_W-1:0];
                    end
                end
            end
            S_ABS: begin
                r_sign   <= r_rdata[RES_W-1];
                r_mag    <= r_rdata[RES_W-1] ? (~r_rdata + 1'b1) : r_rdata;
                r_result <= r_rdata;
            end
            S_SMUL: begin
                r_prod <= r_mag * r_sorig;
            end
            S_SD_WAIT: begin
                // Scaling truncates the magnitude toward zero and restores the sign.
                if (div_rsp.done) begin
                    if (r_sign) begin
                        r_result <= -$signed(div_rsp.quot[RES_W-1:0]);
                    end else begin
                        r_result <= $signed(div_rsp.quot[RES_W-1:0]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register payload, loaded in S_OUT whenever the previous result has gone or is leaving.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && can_load) begin
            r_out_res   <= r_result;
            r_out_ratio <= r_ratio;
            r_out_above <= r_above;
            r_out_last  <= last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_residual_sample = r_out_res;
    assign o_energy_ratio    = r_out_ratio;
    assign o_above_threshold = r_out_above;
    assign o_frame_last      = r_out_last;

endmodule

// ===== src/rfn_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, with a preloaded partial remainder.
// Depends on rfn_pkg for widths and the request and response structs.
module rfn_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfn_pkg::t_div_req i_req,
    output rfn_pkg::t_div_rsp o_rsp
);
    import rfn_pkg::*;

    logic [ACC_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_quot;
    logic [ACC_W-1:0]  r_div;
    logic [STEP_W-1:0] r_left;
    logic              r_busy;
    logic              r_done;

    logic [ACC_W:0]   trial;
    logic             n_bit;
    logic [ACC_W-1:0] n_rem;

    // The partial remainder stays below the divisor, so one compare and subtract per bit.
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        n_bit = (trial >= {1'b0, r_div});
        if (n_bit) begin
            n_rem = ACC_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_left == STEP_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_left == STEP_W'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.preload;
            r_num  <= i_req.numer;
            r_div  <= i_req.divisor;
            r_left <= i_req.steps;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[NUM_W-2:0], n_bit};
            r_left <= r_left - STEP_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ===== src/rfn_accum.sv =====
// Windowed magnitude accumulators for residual and original samples.
// Depends on rfn_pkg for widths and the control struct.
module rfn_accum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rfn_pkg::t_acc_ctrl           i_ctrl,
    input  logic [rfn_pkg::RES_W-1:0]    i_res_mag,
    input  logic [rfn_pkg::SAMPLE_W-1:0] i_orig_mag,
    input  logic [rfn_pkg::COEF_W-1:0]   i_coef,
    output logic [rfn_pkg::ACC_W-1:0]    o_res_acc,
    output logic [rfn_pkg::ACC_W-1:0]    o_orig_acc
);
    import rfn_pkg::*;

    logic [RES_W-1:0]           r_res_mag;
    logic [SAMPLE_W-1:0]        r_orig_mag;
    logic [COEF_W-1:0]          r_coef;
    logic [RES_W+COEF_W-1:0]    r_res_prod;
    logic [SAMPLE_W+COEF_W-1:0] r_orig_prod;
    logic [ACC_W-1:0]           r_res_acc;
    logic [ACC_W-1:0]           r_orig_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_res_mag  <= i_res_mag;
            r_orig_mag <= i_orig_mag;
            r_coef     <= i_coef;
        end
        if (i_ctrl.mul) begin
            r_res_prod  <= r_res_mag * r_coef;
            r_orig_prod <= r_orig_mag * r_coef;
        end
    end

    // Sums wrap at the accumulator width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_acc  <= '0;
            r_orig_acc <= '0;
        end else if (i_ctrl.clear) begin
            r_res_acc  <= '0;
            r_orig_acc <= '0;
        end else if (i_ctrl.add) begin
            r_res_acc  <= r_res_acc + ACC_W'(r_res_prod);
            r_orig_acc <= r_orig_acc + ACC_W'(r_orig_prod);
        end
    end

    assign o_res_acc  = r_res_acc;
    assign o_orig_acc = r_orig_acc;

endmodule
